@@ sv/bmlz_pkg.sv @@
// ---------------------------------------------------------------------------
// bmlz_pkg: shared types and constants of the bit-flag LZ decompressor
// Holds the grammar phases, the core state codes and the stream widths.
// ---------------------------------------------------------------------------
package bmlz_pkg;

  localparam int unsigned WinDepth  = 4096;
  localparam int unsigned WinAw     = $clog2(WinDepth);
  localparam int unsigned LaneBytes = 8;
  localparam int unsigned LaneW     = LaneBytes * 8;
  localparam int unsigned CntW      = 4;
  localparam int unsigned LimW      = 24;
  localparam logic [LimW-1:0] LimMax = '1;

  // Configuration register indexes.
  localparam logic [1:0] CfgInLimit  = 2'd0;
  localparam logic [1:0] CfgOutLimit = 2'd1;

  // Grammar position of the decoder.
  typedef enum logic [4:0] {
    PH_SKIP1    = 5'd0,
    PH_SKIP2    = 5'd1,
    PH_TOP      = 5'd2,
    PH_LITBYTE  = 5'd3,
    PH_B2       = 5'd4,
    PH_LENA     = 5'd5,
    PH_LENB     = 5'd6,
    PH_LENC     = 5'd7,
    PH_RUN1     = 5'd8,
    PH_RUN2     = 5'd9,
    PH_RUN3     = 5'd10,
    PH_RUN4     = 5'd11,
    PH_RUNBYTE  = 5'd12,
    PH_B3       = 5'd13,
    PH_B4       = 5'd14,
    PH_SHORTOFF = 5'd15,
    PH_LONGLEN  = 5'd16,
    PH_ENDBIT   = 5'd17,
    PH_OFF1     = 5'd18,
    PH_OFF2     = 5'd19,
    PH_OFF3     = 5'd20,
    PH_OFF4     = 5'd21,
    PH_OFF5     = 5'd22,
    PH_OFF6     = 5'd23,
    PH_OFF7     = 5'd24,
    PH_OFFLOW   = 5'd25,
    PH_DONE     = 5'd26
  } phase_e;

  // Sequencer state of the back end.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_RUN  = 3'd1,
    ST_CRD  = 3'd2,
    ST_CWR  = 3'd3,
    ST_END  = 3'd4
  } state_e;

  // One queued request from the front end.
  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } item_t;

endpackage

@@ sv/bitflag_lz_decompressor_m2.sv @@
// ---------------------------------------------------------------------------
// bitflag_lz_decompressor_m2: bit-flag LZ (method 2) stream decompressor
// Decodes one compressed byte per request into words of up to eight bytes.
// ---------------------------------------------------------------------------
// Steps: a request passes through the input queue to the decoder; each
// flag bit or raw byte is one grammar step, each copied match byte a history
// read, then a write-back; a closing word carries pending bytes or the stop.
// The input queue takes new requests while the core is still busy.
// Reset: asynchronous, active low; clears control state and both limits to
// all ones. The history window is not cleared.
module bitflag_lz_decompressor_m2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] stream_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] out_bytes, [67:64] byte_count, rest zero
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [0] done_res, [1] error
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  logic [bmlz_pkg::LimW-1:0] in_lim_q, out_lim_q;
  bmlz_pkg::item_t           in_item, q_item;
  logic                      q_valid, q_pop;
  logic [bmlz_pkg::LaneW-1:0] res_bytes;
  logic [bmlz_pkg::CntW-1:0]  res_count;
  logic                       res_done, res_err;

  assign in_item.start = s_axis_tuser;
  assign in_item.data  = s_axis_tdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_lim_q  <= bmlz_pkg::LimMax;
      out_lim_q <= bmlz_pkg::LimMax;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bmlz_pkg::CfgInLimit) in_lim_q <= cfg_data_i;
      if (cfg_idx_i == bmlz_pkg::CfgOutLimit) out_lim_q <= cfg_data_i;
    end
  end

  bmlz_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (q_valid),
    .out_pop_i   (q_pop),
    .out_item_o  (q_item)
  );

  bmlz_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_limit_i   (in_lim_q),
    .out_limit_i  (out_lim_q),
    .item_valid_i (q_valid),
    .item_pop_o   (q_pop),
    .item_i       (q_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_bytes_o  (res_bytes),
    .res_count_o  (res_count),
    .res_last_o   (m_axis_tlast),
    .res_done_o   (res_done),
    .res_err_o    (res_err)
  );

  assign m_axis_tdata = {4'd0, res_count, res_bytes};
  assign m_axis_tuser = {res_err, res_done};

endmodule

@@ sv/bmlz_ram.sv @@
// ---------------------------------------------------------------------------
// bmlz_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bmlz_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/bmlz_front.sv @@
// ---------------------------------------------------------------------------
// bmlz_front: input queue of the decompressor
// Accepts compressed bytes into a two-entry queue for the decoder.
// ---------------------------------------------------------------------------
module bmlz_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bmlz_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_pop_i,
  output bmlz_pkg::item_t out_item_o
);

  bmlz_pkg::item_t buf_q [2];
  logic       rd_q, rd_d;
  logic       wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = buf_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (out_pop_i) begin
      rd_d = ~rd_q;
    end
    if (push && !out_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && out_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_item_i;
    end
  end

endmodule

@@ sv/bmlz_core.sv @@
// ---------------------------------------------------------------------------
// bmlz_core: decoding back end of the decompressor
// Walks the flag-bit grammar one step a cycle unless a full word stalls it,
// copies matches from the history window and packs bytes into output words.
// ---------------------------------------------------------------------------
module bmlz_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bmlz_pkg::LimW-1:0]     in_limit_i,
  input  logic [bmlz_pkg::LimW-1:0]     out_limit_i,
  input  logic                          item_valid_i,
  output logic                          item_pop_o,
  input  bmlz_pkg::item_t               item_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [bmlz_pkg::LaneW-1:0]    res_bytes_o,
  output logic [bmlz_pkg::CntW-1:0]     res_count_o,
  output logic                          res_last_o,
  output logic                          res_done_o,
  output logic                          res_err_o
);

  bmlz_pkg::state_e st_q, st_d;
  bmlz_pkg::phase_e ph_q, ph_d;

  logic [7:0]                   flags_q, flags_d;
  logic [8:0]                   plen_q, plen_d;
  logic [12:0]                  poff_q, poff_d;
  logic [6:0]                   lit_q, lit_d;
  logic [bmlz_pkg::WinAw-1:0]   wpos_q, wpos_d;
  logic [bmlz_pkg::LimW-1:0]    prod_q, prod_d;
  logic [bmlz_pkg::LimW-1:0]    cons_q, cons_d;
  logic                         fin_q, fin_d;
  logic                         have_q, have_d;
  logic [7:0]                   byte_q, byte_d;
  logic                         sstop_q, sstop_d;
  logic                         serr_q, serr_d;
  logic [bmlz_pkg::LaneW-1:0]   lane_q, lane_d;
  logic [bmlz_pkg::CntW-1:0]    cnt_q, cnt_d;

  logic                         ov_q, ov_d;
  logic [bmlz_pkg::LaneW-1:0]   od_q, od_d;
  logic [bmlz_pkg::CntW-1:0]    oc_q, oc_d;
  logic                         ol_q, ol_d;
  logic                         odn_q, odn_d;
  logic                         oer_q, oer_d;

  logic                         ram_we;
  logic [bmlz_pkg::WinAw-1:0]   ram_waddr;
  logic [7:0]                   ram_wdata;
  logic [bmlz_pkg::WinAw-1:0]   ram_raddr;
  logic [7:0]                   ram_rdata;

  logic                         ofree;
  logic                         lane_full;
  logic                         at_limit;
  logic                         needs_byte;
  logic                         bit_ok;
  logic                         bit_v;
  logic [12:0]                  off_low;
  logic [12:0]                  off_short;
  logic [4:0]                   run_sum;
  logic [6:0]                   lit_dec;

  assign ofree     = !ov_q || res_ready_i;
  assign lane_full = (cnt_q == bmlz_pkg::CntW'(bmlz_pkg::LaneBytes));
  assign at_limit  = (prod_q >= out_limit_i);
  assign needs_byte = (ph_q == bmlz_pkg::PH_LITBYTE) || (ph_q == bmlz_pkg::PH_RUNBYTE) ||
                      (ph_q == bmlz_pkg::PH_SHORTOFF) || (ph_q == bmlz_pkg::PH_LONGLEN) ||
                      (ph_q == bmlz_pkg::PH_OFFLOW);
  assign bit_ok    = (flags_q[6:0] != 7'd0) || have_q;
  assign bit_v     = (flags_q[6:0] != 7'd0) ? flags_q[7] : byte_q[7];
  assign off_low   = 13'({poff_q[3:0], byte_q}) + 13'd1;
  assign off_short = 13'(byte_q) + 13'd1;
  assign run_sum   = 5'({lit_q[3:0], bit_v}) + 5'd3;
  assign lit_dec   = (lit_q != 7'd0) ? (lit_q - 7'd1) : 7'd0;

  assign res_valid_o = ov_q;
  assign res_bytes_o = od_q;
  assign res_count_o = oc_q;
  assign res_last_o  = ol_q;
  assign res_done_o  = odn_q;
  assign res_err_o   = oer_q;

  bmlz_ram #(
    .Width (8),
    .Depth (bmlz_pkg::WinDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      bmlz_pkg::ST_IDLE: begin
        if (item_valid_i && !(fin_q && !item_i.start)) begin
          st_d = bmlz_pkg::ST_RUN;
        end
      end
      bmlz_pkg::ST_RUN: begin
        if (ph_q == bmlz_pkg::PH_DONE) begin
          st_d = bmlz_pkg::ST_END;
        end else if (needs_byte) begin
          if (!have_q) begin
            st_d = bmlz_pkg::ST_END;
          end else if (ph_q == bmlz_pkg::PH_SHORTOFF) begin
            st_d = (off_short > 13'(prod_q)) && (prod_q < 24'd4096) ?
                   bmlz_pkg::ST_END : bmlz_pkg::ST_CRD;
          end else if (ph_q == bmlz_pkg::PH_OFFLOW) begin
            st_d = (24'(off_low) > prod_q) ? bmlz_pkg::ST_END : bmlz_pkg::ST_CRD;
          end
        end else if (!bit_ok) begin
          st_d = bmlz_pkg::ST_END;
        end
      end
      bmlz_pkg::ST_CRD: begin
        if (plen_q == 9'd0) begin
          st_d = bmlz_pkg::ST_RUN;
        end else if (at_limit) begin
          st_d = bmlz_pkg::ST_END;
        end else if (!lane_full) begin
          st_d = bmlz_pkg::ST_CWR;
        end
      end
      bmlz_pkg::ST_CWR: st_d = bmlz_pkg::ST_CRD;
      bmlz_pkg::ST_END: begin
        if ((cnt_q == '0 && !sstop_q) || ofree) begin
          st_d = bmlz_pkg::ST_IDLE;
        end
      end
      default: st_d = bmlz_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output strobes.
  always_comb begin
    ph_d    = ph_q;
    flags_d = flags_q;
    plen_d  = plen_q;
    poff_d  = poff_q;
    lit_d   = lit_q;
    wpos_d  = wpos_q;
    prod_d  = prod_q;
    cons_d  = cons_q;
    fin_d   = fin_q;
    have_d  = have_q;
    byte_d  = byte_q;
    sstop_d = sstop_q;
    serr_d  = serr_q;
    lane_d  = lane_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !res_ready_i;
    od_d    = od_q;
    oc_d    = oc_q;
    ol_d    = ol_q;
    odn_d   = odn_q;
    oer_d   = oer_q;
    item_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wpos_q;
    ram_wdata = byte_q;
    ram_raddr = wpos_q - poff_q[bmlz_pkg::WinAw-1:0];

    unique case (st_q)
      // Take the next queued byte, clearing the stream on a start mark.
      bmlz_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.start) begin
            flags_d = 8'd0;
            ph_d    = bmlz_pkg::PH_SKIP1;
            plen_d  = 9'd0;
            poff_d  = 13'd0;
            lit_d   = 7'd0;
            wpos_d  = '0;
            prod_d  = '0;
            cons_d  = 24'd1;
            fin_d   = 1'b0;
          end else if (cons_q != bmlz_pkg::LimMax) begin
            cons_d = cons_q + 24'd1;
          end
          have_d  = 1'b1;
          byte_d  = item_i.data;
          sstop_d = 1'b0;
          serr_d  = 1'b0;
        end
      end

      // One grammar step per cycle, held while a full word waits for the receiver.
      bmlz_pkg::ST_RUN: begin
        if (ph_q == bmlz_pkg::PH_DONE) begin
          ph_d = bmlz_pkg::PH_DONE;
        end else if (needs_byte) begin
          if (have_q) begin
            priority case (ph_q)
              bmlz_pkg::PH_LITBYTE, bmlz_pkg::PH_RUNBYTE: begin
                if (at_limit) begin
                  have_d = 1'b0;
                  fin_d = 1'b1; ph_d = bmlz_pkg::PH_DONE;
                  sstop_d = 1'b1; serr_d = 1'b1;
                end else if (lane_full) begin
                  if (ofree) begin
                    ov_d = 1'b1; od_d = lane_q; oc_d = cnt_q;
                    ol_d = 1'b0; odn_d = 1'b0; oer_d = 1'b0;
                    lane_d = '0; cnt_d = '0;
                  end
                end else begin
                  have_d = 1'b0;
                  ram_we = 1'b1;
                  lane_d[{cnt_q[2:0], 3'b000} +: 8] = byte_q;
                  cnt_d  = cnt_q + 4'd1;
                  wpos_d = wpos_q + 1'b1;
                  prod_d = prod_q + 24'd1;
                  if (ph_q == bmlz_pkg::PH_LITBYTE) begin
                    ph_d = bmlz_pkg::PH_TOP;
                  end else begin
                    lit_d = lit_dec;
                    if (lit_dec == 7'd0) ph_d = bmlz_pkg::PH_TOP;
                  end
                end
              end
              bmlz_pkg::PH_SHORTOFF: begin
                have_d = 1'b0;
                plen_d = 9'd2;
                poff_d = off_short;
                if (24'(off_short) > prod_q) begin
                  fin_d = 1'b1; ph_d = bmlz_pkg::PH_DONE;
                  sstop_d = 1'b1; serr_d = 1'b1;
                end
              end
              bmlz_pkg::PH_LONGLEN: begin
                have_d = 1'b0;
                if (byte_q == 8'd0) begin
                  ph_d = bmlz_pkg::PH_ENDBIT;
                end else begin
                  plen_d = 9'(byte_q) + 9'd8;
                  ph_d = bmlz_pkg::PH_OFF1;
                end
              end
              default: begin
                have_d = 1'b0;
                poff_d = off_low;
                if (24'(off_low) > prod_q) begin
                  fin_d = 1'b1; ph_d = bmlz_pkg::PH_DONE;
                  sstop_d = 1'b1; serr_d = 1'b1;
                end
              end
            endcase
          end
        end else if (bit_ok) begin
          // Fetch one flag bit, refilling from the byte when empty.
          if (flags_q[6:0] != 7'd0) begin
            flags_d = {flags_q[6:0], 1'b0};
          end else begin
            have_d  = 1'b0;
            flags_d = {byte_q[6:0], 1'b1};
          end
          priority case (ph_q)
            bmlz_pkg::PH_SKIP1: ph_d = bmlz_pkg::PH_SKIP2;
            bmlz_pkg::PH_SKIP2: ph_d = bmlz_pkg::PH_TOP;
            bmlz_pkg::PH_TOP:
              ph_d = bit_v ? bmlz_pkg::PH_B2 : bmlz_pkg::PH_LITBYTE;
            bmlz_pkg::PH_B2:
              ph_d = bit_v ? bmlz_pkg::PH_B3 : bmlz_pkg::PH_LENA;
            bmlz_pkg::PH_LENA: begin
              plen_d = 9'd4 + 9'(bit_v);
              ph_d = bmlz_pkg::PH_LENB;
            end
            bmlz_pkg::PH_LENB:
              ph_d = bit_v ? bmlz_pkg::PH_LENC : bmlz_pkg::PH_OFF1;
            bmlz_pkg::PH_LENC: begin
              plen_d = 9'({plen_q[7:0] - 8'd1, bit_v});
              if ({plen_q[7:0] - 8'd1, bit_v} == 9'd9) begin
                lit_d = 7'd0;
                ph_d = bmlz_pkg::PH_RUN1;
              end else begin
                ph_d = bmlz_pkg::PH_OFF1;
              end
            end
            bmlz_pkg::PH_RUN1, bmlz_pkg::PH_RUN2, bmlz_pkg::PH_RUN3: begin
              lit_d = {lit_q[5:0], bit_v};
              ph_d = bmlz_pkg::phase_e'(ph_q + 5'd1);
            end
            bmlz_pkg::PH_RUN4: begin
              lit_d = {run_sum, 2'b00};
              ph_d = bmlz_pkg::PH_RUNBYTE;
            end
            bmlz_pkg::PH_B3:
              ph_d = bit_v ? bmlz_pkg::PH_B4 : bmlz_pkg::PH_SHORTOFF;
            bmlz_pkg::PH_B4: begin
              if (bit_v) begin
                ph_d = bmlz_pkg::PH_LONGLEN;
              end else begin
                plen_d = 9'd3;
                ph_d = bmlz_pkg::PH_OFF1;
              end
            end
            bmlz_pkg::PH_ENDBIT: begin
              if (bit_v) begin
                ph_d = bmlz_pkg::PH_TOP;
              end else begin
                fin_d = 1'b1; ph_d = bmlz_pkg::PH_DONE;
                sstop_d = 1'b1; serr_d = (cons_q > in_limit_i);
              end
            end
            bmlz_pkg::PH_OFF1: begin
              poff_d = 13'd0;
              ph_d = bit_v ? bmlz_pkg::PH_OFF2 : bmlz_pkg::PH_OFFLOW;
            end
            bmlz_pkg::PH_OFF2: begin
              poff_d = 13'(bit_v);
              ph_d = bmlz_pkg::PH_OFF3;
            end
            bmlz_pkg::PH_OFF3: begin
              if (bit_v) ph_d = bmlz_pkg::PH_OFF4;
              else ph_d = (poff_q == 13'd0) ? bmlz_pkg::PH_OFF6 : bmlz_pkg::PH_OFFLOW;
            end
            bmlz_pkg::PH_OFF4: begin
              poff_d = 13'({poff_q[10:0], bit_v}) + 13'd4;
              ph_d = bmlz_pkg::PH_OFF5;
            end
            bmlz_pkg::PH_OFF5:
              ph_d = bit_v ? bmlz_pkg::PH_OFFLOW : bmlz_pkg::PH_OFF7;
            bmlz_pkg::PH_OFF6: begin
              poff_d = 13'(bit_v) + 13'd2;
              ph_d = bmlz_pkg::PH_OFFLOW;
            end
            bmlz_pkg::PH_OFF7: begin
              poff_d = {poff_q[11:0], bit_v};
              ph_d = bmlz_pkg::PH_OFFLOW;
            end
            default: begin
              fin_d = 1'b1; ph_d = bmlz_pkg::PH_DONE;
              sstop_d = 1'b1; serr_d = 1'b1;
            end
          endcase
        end
      end

      // Match copy: issue the history read.
      bmlz_pkg::ST_CRD: begin
        if (plen_q == 9'd0) begin
          ph_d = bmlz_pkg::PH_TOP;
        end else if (at_limit) begin
          fin_d = 1'b1; ph_d = bmlz_pkg::PH_DONE;
          sstop_d = 1'b1; serr_d = 1'b1;
        end else if (lane_full) begin
          if (ofree) begin
            ov_d = 1'b1; od_d = lane_q; oc_d = cnt_q;
            ol_d = 1'b0; odn_d = 1'b0; oer_d = 1'b0;
            lane_d = '0; cnt_d = '0;
          end
        end
      end

      // Match copy: write the byte back and pack it.
      bmlz_pkg::ST_CWR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        lane_d[{cnt_q[2:0], 3'b000} +: 8] = ram_rdata;
        cnt_d  = cnt_q + 4'd1;
        wpos_d = wpos_q + 1'b1;
        prod_d = prod_q + 24'd1;
        plen_d = plen_q - 9'd1;
      end

      // Close the step with its final word when bytes are pending or the stream stopped.
      bmlz_pkg::ST_END: begin
        if ((cnt_q != '0 || sstop_q) && ofree) begin
          ov_d = 1'b1; od_d = lane_q; oc_d = cnt_q;
          ol_d = 1'b1; odn_d = sstop_q; oer_d = serr_q;
          lane_d = '0; cnt_d = '0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= bmlz_pkg::ST_IDLE;
      ph_q    <= bmlz_pkg::PH_SKIP1;
      flags_q <= 8'd0;
      plen_q  <= 9'd0;
      poff_q  <= 13'd0;
      lit_q   <= 7'd0;
      wpos_q  <= '0;
      prod_q  <= '0;
      cons_q  <= '0;
      fin_q   <= 1'b0;
      have_q  <= 1'b0;
      sstop_q <= 1'b0;
      serr_q  <= 1'b0;
      lane_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      ph_q    <= ph_d;
      flags_q <= flags_d;
      plen_q  <= plen_d;
      poff_q  <= poff_d;
      lit_q   <= lit_d;
      wpos_q  <= wpos_d;
      prod_q  <= prod_d;
      cons_q  <= cons_d;
      fin_q   <= fin_d;
      have_q  <= have_d;
      sstop_q <= sstop_d;
      serr_q  <= serr_d;
      lane_q  <= lane_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    od_q   <= od_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
    odn_q  <= odn_d;
    oer_q  <= oer_d;
  end

endmodule

@@ tb/bitflag_lz_decompressor_m2_tb.sv @@
// ---------------------------------------------------------------------------
// bitflag_lz_decompressor_m2_tb: self-checking bench of the LZ decompressor
// Streams well-formed and broken compressed streams into the block with
// random sender gaps and receiver stalls. Every output word is checked
// against a behavioral decoder that runs beside the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected output words in arrival order; compares each word the block sends.
class word_scoreboard;
  logic [71:0] exp_data[$];
  logic        exp_last[$];
  logic [1:0]  exp_user[$];
  int          mismatches;

  function void note_word(logic [63:0] bytes, logic [3:0] cnt, logic lst, logic dn,
                          logic err);
    exp_data.push_back({4'b0, cnt, bytes});
    exp_last.push_back(lst);
    exp_user.push_back({err, dn});
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task check_word(logic [71:0] d, logic l, logic [1:0] u);
    logic [71:0] ed;
    if (exp_data.size() == 0) begin
      report($sformatf("unexpected word %h", d));
      return;
    end
    ed = exp_data.pop_front();
    if (d[63:0] !== ed[63:0]) report($sformatf("bytes %h exp %h", d[63:0], ed[63:0]));
    if (d[71:64] !== ed[71:64]) report($sformatf("count %h exp %h", d[71:64], ed[71:64]));
    if (l !== exp_last[0]) report($sformatf("last %b exp %b", l, exp_last[0]));
    if (u !== exp_user[0]) report($sformatf("user %b exp %b", u, exp_user[0]));
    void'(exp_last.pop_front());
    void'(exp_user.pop_front());
  endtask
endclass

module bitflag_lz_decompressor_m2_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  word_scoreboard sb = new();

  // Decoder state mirrored by the bench.
  logic [23:0] lim_in, lim_out;
  logic [7:0]  fbits;
  bmlz_pkg::phase_e ph;
  int unsigned plen, poff, lit_left, wpos, produced, consumed;
  bit          stopped;
  logic [7:0]  win[bmlz_pkg::WinDepth];
  logic [7:0]  step_bytes[$];
  bit          step_stop, step_err;

  // Stream under construction for the sender.
  logic [7:0]  strm[$];
  int unsigned bit_slot;
  int unsigned flag_idx;
  int unsigned hold_cycles;
  int unsigned cycles;

  always #5 clk_i = ~clk_i;

  bitflag_lz_decompressor_m2 u_top (.*);

  // ---- behavioral decoder ----
  function automatic void halt(bit err);
    stopped = 1;
    ph = bmlz_pkg::PH_DONE;
    step_stop = 1;
    step_err = err;
  endfunction

  function automatic bit emit(logic [7:0] v);
    if (produced >= lim_out) begin
      halt(1);
      return 0;
    end
    win[wpos] = v;
    wpos = (wpos + 1) % bmlz_pkg::WinDepth;
    produced++;
    step_bytes.push_back(v);
    return 1;
  endfunction

  function automatic void copy_match();
    if (poff > produced || poff == 0) begin
      halt(1);
      return;
    end
    for (int i = 0; i < plen; i++)
      if (!emit(win[(wpos + bmlz_pkg::WinDepth - poff) % bmlz_pkg::WinDepth])) return;
    ph = bmlz_pkg::PH_TOP;
  endfunction

  function automatic void take_raw(logic [7:0] b);
    case (ph)
      bmlz_pkg::PH_LITBYTE: if (emit(b)) ph = bmlz_pkg::PH_TOP;
      bmlz_pkg::PH_RUNBYTE: begin
        if (emit(b)) begin
          if (lit_left > 0) lit_left--;
          if (lit_left == 0) ph = bmlz_pkg::PH_TOP;
        end
      end
      bmlz_pkg::PH_SHORTOFF: begin
        plen = 2;
        poff = b + 1;
        copy_match();
      end
      bmlz_pkg::PH_LONGLEN: begin
        if (b == 0) ph = bmlz_pkg::PH_ENDBIT;
        else begin
          plen = b + 8;
          ph = bmlz_pkg::PH_OFF1;
        end
      end
      default: begin
        poff = ((poff & 15) << 8) + b + 1;
        copy_match();
      end
    endcase
  endfunction

  function automatic void take_flag(int unsigned f);
    case (ph)
      bmlz_pkg::PH_SKIP1: ph = bmlz_pkg::PH_SKIP2;
      bmlz_pkg::PH_SKIP2: ph = bmlz_pkg::PH_TOP;
      bmlz_pkg::PH_TOP:   ph = f ? bmlz_pkg::PH_B2 : bmlz_pkg::PH_LITBYTE;
      bmlz_pkg::PH_B2:    ph = f ? bmlz_pkg::PH_B3 : bmlz_pkg::PH_LENA;
      bmlz_pkg::PH_LENA: begin
        plen = 4 + f;
        ph = bmlz_pkg::PH_LENB;
      end
      bmlz_pkg::PH_LENB:  ph = f ? bmlz_pkg::PH_LENC : bmlz_pkg::PH_OFF1;
      bmlz_pkg::PH_LENC: begin
        plen = (plen - 1) * 2 + f;
        if (plen == 9) begin
          lit_left = 0;
          ph = bmlz_pkg::PH_RUN1;
        end else ph = bmlz_pkg::PH_OFF1;
      end
      bmlz_pkg::PH_RUN1, bmlz_pkg::PH_RUN2, bmlz_pkg::PH_RUN3: begin
        lit_left = lit_left * 2 + f;
        ph = bmlz_pkg::phase_e'(ph + 1);
      end
      bmlz_pkg::PH_RUN4: begin
        lit_left = (lit_left * 2 + f + 3) * 4;
        ph = bmlz_pkg::PH_RUNBYTE;
      end
      bmlz_pkg::PH_B3: ph = f ? bmlz_pkg::PH_B4 : bmlz_pkg::PH_SHORTOFF;
      bmlz_pkg::PH_B4: begin
        if (f) ph = bmlz_pkg::PH_LONGLEN;
        else begin
          plen = 3;
          ph = bmlz_pkg::PH_OFF1;
        end
      end
      bmlz_pkg::PH_ENDBIT: begin
        if (f) ph = bmlz_pkg::PH_TOP;
        else halt(consumed > lim_in);
      end
      bmlz_pkg::PH_OFF1: begin
        poff = 0;
        ph = f ? bmlz_pkg::PH_OFF2 : bmlz_pkg::PH_OFFLOW;
      end
      bmlz_pkg::PH_OFF2: begin
        poff = f;
        ph = bmlz_pkg::PH_OFF3;
      end
      bmlz_pkg::PH_OFF3:
        ph = f ? bmlz_pkg::PH_OFF4 :
             ((poff == 0) ? bmlz_pkg::PH_OFF6 : bmlz_pkg::PH_OFFLOW);
      bmlz_pkg::PH_OFF4: begin
        poff = poff * 2 + 4 + f;
        ph = bmlz_pkg::PH_OFF5;
      end
      bmlz_pkg::PH_OFF5: ph = f ? bmlz_pkg::PH_OFFLOW : bmlz_pkg::PH_OFF7;
      bmlz_pkg::PH_OFF6: begin
        poff = f + 2;
        ph = bmlz_pkg::PH_OFFLOW;
      end
      bmlz_pkg::PH_OFF7: begin
        poff = poff * 2 + f;
        ph = bmlz_pkg::PH_OFFLOW;
      end
      default: halt(1);
    endcase
  endfunction

  function automatic void restart_stream();
    fbits = 0;
    ph = bmlz_pkg::PH_SKIP1;
    plen = 0;
    poff = 0;
    lit_left = 0;
    wpos = 0;
    produced = 0;
    consumed = 0;
    stopped = 0;
  endfunction

  // Runs one accepted request through the decoder and queues its words.
  function automatic void decode_request(logic [7:0] b, logic first);
    bit have;
    int unsigned f, nwords, n;
    logic [63:0] w;
    if (first) restart_stream();
    if (stopped) return;
    if (consumed < 24'hFFFFFF) consumed++;
    step_bytes.delete();
    step_stop = 0;
    step_err = 0;
    have = 1;
    while (ph != bmlz_pkg::PH_DONE) begin
      if (ph inside {bmlz_pkg::PH_LITBYTE, bmlz_pkg::PH_RUNBYTE, bmlz_pkg::PH_SHORTOFF,
                     bmlz_pkg::PH_LONGLEN, bmlz_pkg::PH_OFFLOW}) begin
        if (!have) break;
        have = 0;
        take_raw(b);
      end else begin
        if ((fbits & 8'h7F) != 0) begin
          f = fbits[7];
          fbits = fbits << 1;
        end else if (have) begin
          have = 0;
          f = b[7];
          fbits = {b[6:0], 1'b1};
        end else break;
        take_flag(f);
      end
    end
    nwords = (step_bytes.size() + bmlz_pkg::LaneBytes - 1) / bmlz_pkg::LaneBytes;
    if (nwords == 0 && step_stop) nwords = 1;
    for (int k = 0; k < nwords; k++) begin
      w = '0;
      n = 0;
      for (int i = 0; i < bmlz_pkg::LaneBytes; i++)
        if (k * bmlz_pkg::LaneBytes + i < step_bytes.size()) begin
          w[8*i +: 8] = step_bytes[k * bmlz_pkg::LaneBytes + i];
          n++;
        end
      sb.note_word(w, n[3:0], k + 1 == nwords, (k + 1 == nwords) && step_stop,
                   (k + 1 == nwords) && step_err);
    end
  endfunction

  // ---- stream builder: flag bits are packed into bytes as the decoder reads them ----
  // A refill byte is placed where the decoder first runs out of flag bits and
  // supplies eight bits, most significant first.
  function automatic void put_flag(bit f);
    if (bit_slot == 0) begin
      strm.push_back(8'h00);
      flag_idx = strm.size() - 1;
      bit_slot = 8;
    end
    bit_slot--;
    strm[flag_idx][bit_slot] = f;
  endfunction

  function automatic void put_bits(int unsigned v, int nb);
    for (int i = nb - 1; i >= 0; i--) put_flag(v[i]);
  endfunction

  // Offset code: value o in 1..4096, low byte raw.
  function automatic void put_offset(int unsigned o);
    int unsigned hi;
    hi = (o - 1) >> 8;
    if (hi == 0) put_flag(0);
    else if (hi == 1) put_bits(3'b110, 3);
    else if (hi <= 3) put_bits({3'b100, hi[0]}, 4);
    else if (hi <= 7) put_bits({1'b1, hi[1], 1'b1, hi[0], 1'b1}, 5);
    else put_bits({1'b1, hi[2], 1'b1, hi[1], 1'b0, hi[0]}, 6);
    strm.push_back(o[7:0] - 8'd1);
  endfunction

  function automatic void put_lit(logic [7:0] v);
    put_flag(0);
    strm.push_back(v);
  endfunction

  // Short match, length 2, offset 1..256.
  function automatic void put_short(int unsigned o);
    put_bits(3'b110, 3);
    strm.push_back(o[7:0] - 8'd1);
  endfunction

  // Long match: length 9..263, offset 1..4096.
  function automatic void put_long(int unsigned len, int unsigned o);
    put_bits(4'b1111, 4);
    strm.push_back(8'(len - 8));
    put_offset(o);
  endfunction

  // Literal run of 12..72 bytes in steps of four.
  function automatic void put_run(int unsigned cnt);
    int unsigned c;
    c = cnt / 4 - 3;
    put_bits(5'b10111, 5);
    put_bits(c, 4);
    repeat (cnt) strm.push_back(8'($urandom));
  endfunction

  function automatic void put_end(bit go_on);
    put_bits(4'b1111, 4);
    strm.push_back(8'h00);
    put_flag(go_on);
  endfunction

  // Builds one stream with random content; may add a continuing end marker or a bad offset.
  function automatic void build_stream(int unsigned tokens, bit bad_off);
    int unsigned made;
    strm.delete();
    bit_slot = 0;
    put_bits(2'b00, 2);
    made = 0;
    repeat (tokens) begin
      case ((made == 0) ? 0 : $urandom_range(0, 5))
        0, 1: begin
          put_lit(8'($urandom));
          made++;
        end
        2: begin
          put_short($urandom_range(1, (made < 256) ? made : 256));
          made += 2;
        end
        3: begin
          put_long($urandom_range(9, 40), $urandom_range(1, made));
          made += 9;
        end
        4: begin
          put_run(4 * $urandom_range(3, 4));
          made += 12;
        end
        default: begin
          put_bits(4'b1000, 4);
          put_offset($urandom_range(1, made));
          made += 4;
        end
      endcase
    end
    if (bad_off) put_short(made + 1 <= 256 ? made + 1 : 256);
    if ($urandom_range(0, 3) == 0) put_end(1);
    put_end(0);
  endfunction

  // ---- drivers ----
  task automatic send_byte(logic [7:0] b, logic first);
    while ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_request(b, first);
  endtask

  task automatic send_stream();
    foreach (strm[i]) send_byte(strm[i], i == 0);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.exp_data.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bmlz_pkg::CfgInLimit) lim_in = val;
    else if (idx == bmlz_pkg::CfgOutLimit) lim_out = val;
    @(posedge clk_i);
  endtask

  // Receiver: random stall pattern, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (cycles % 2000 < 700) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    hold_cycles = 0;
    lim_in = 24'hFFFFFF;
    lim_out = 24'hFFFFFF;
    restart_stream();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: literals, short, length 4 and 5, long matches, runs, and the end marker with nothing before it.
    strm.delete();
    bit_slot = 0;
    put_bits(2'b11, 2);
    put_end(0);
    send_stream();
    strm.delete();
    bit_slot = 0;
    put_bits(2'b01, 2);
    put_lit(8'h00);
    put_lit(8'hFF);
    put_short(1);
    put_bits(4'b1000, 4);
    put_offset(2);
    put_bits(4'b1010, 4);
    put_offset(1);
    put_run(12);
    put_run(72);
    put_long(263, 4);
    put_long(9, 1);
    put_end(1);
    put_end(0);
    send_stream();
    // Offset before the first byte, and bytes ignored after the stop.
    strm.delete();
    bit_slot = 0;
    put_bits(2'b00, 2);
    put_lit(8'hA5);
    put_short(5);
    strm.push_back(8'h55);
    strm.push_back(8'hAA);
    send_stream();
    drain();

    // Tight limits: output overrun and input overrun.
    write_cfg(bmlz_pkg::CfgOutLimit, 24'd3);
    write_cfg(bmlz_pkg::CfgInLimit, 24'd0);
    build_stream(4, 0);
    send_stream();
    drain();
    write_cfg(bmlz_pkg::CfgOutLimit, 24'd0);
    build_stream(2, 0);
    send_stream();
    drain();
    write_cfg(bmlz_pkg::CfgOutLimit, 24'hFFFFFF);
    write_cfg(bmlz_pkg::CfgInLimit, 24'd12);
    build_stream(3, 0);
    send_stream();
    drain();
    write_cfg(bmlz_pkg::CfgInLimit, 24'hFFFFFF);

    // Long receiver hold-off while the sender keeps offering.
    hold_cycles = 3000;
    build_stream(6, 0);
    send_stream();
    drain();

    // Random streams, mostly well formed, some with bad offsets or noise.
    for (int n = 0; n < 2; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        strm.delete();
        repeat ($urandom_range(5, 20)) strm.push_back(8'($urandom));
      end else build_stream($urandom_range(2, 5), $urandom_range(0, 5) == 0);
      send_stream();
    end
    drain();
    write_cfg(bmlz_pkg::CfgOutLimit, 24'($urandom_range(20, 60)));
    write_cfg(bmlz_pkg::CfgInLimit, 24'($urandom_range(5, 30)));
    for (int n = 0; n < 2; n++) begin
      build_stream($urandom_range(3, 5), 0);
      send_stream();
    end
    drain();

    if (sb.mismatches == 0 && sb.exp_data.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ bitflag_lz_decompressor_m2.f @@
sv/bmlz_pkg.sv
sv/bmlz_ram.sv
sv/bmlz_front.sv
sv/bmlz_core.sv
sv/bitflag_lz_decompressor_m2.sv
tb/bitflag_lz_decompressor_m2_tb.sv
